@@ rtl/core/lsle_pkg.sv @@
`timescale 1ns / 1ps

package lsle_pkg;

    localparam int COLOR_BITS  = 24;
    localparam int MAX_BYTES   = 33;
    localparam int CFG_BITS    = 10;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PREAMBLE_BITS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_SYMBOL   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_SYMBOL    = 2'd2;

    localparam logic [9:0] PREAMBLE_RESET = 10'd133;
    localparam logic [4:0] ZERO_SYM_RESET = 5'd15;
    localparam logic [4:0] ONE_SYM_RESET  = 5'd1;

    typedef struct packed {
        logic [23:0] color;
        logic        start_frame;
        logic        end_frame;
    } t_in_word;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last;
    } t_out_word;

endpackage

@@ rtl/core/led_symbol_line_encoder.sv @@
`timescale 1ns / 1ps
// Each output byte is built from 8 line bits, shifted in one per cycle unless the output stall holds
//   the packer; bits left pending by the previous word fill the first byte unless a frame start drops them.
// A new word is taken only in idle, once the packer is done with the last one: preamble bits (length P,
//   clamped to PRE_LIMIT) on frame start, 24*SYMBOL_BITS data bits, then pad bits to the byte end on frame end.
// Output stall holds the packer only when a completed byte finds the output register full.
// Reset (sync, active low) restores register defaults and empties the packer and output.
module led_symbol_line_encoder #(
    parameter int SYMBOL_BITS = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lsle_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lsle_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [lsle_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [lsle_pkg::CFG_BITS-1:0]       i_cfg_data
);

    localparam int PRE_LIMIT = lsle_pkg::MAX_BYTES * 8 - lsle_pkg::COLOR_BITS * SYMBOL_BITS;
    localparam int SCW       = $clog2(SYMBOL_BITS);
    localparam logic [SCW-1:0] SYM_LAST = SCW'(SYMBOL_BITS - 1);
    localparam logic [4:0]     DATA_LAST = 5'(lsle_pkg::COLOR_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_DATA,
        ST_PAD
    } t_state;

    t_state r_state;

    logic [9:0]             r_pre_len;
    logic [4:0]             r_zero_sym;
    logic [4:0]             r_one_sym;

    logic [23:0]            r_color;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic [SCW-1:0]         r_sym_cnt;
    logic [4:0]             r_data_cnt;
    logic [9:0]             r_pre_cnt;
    logic                   r_end;
    logic [7:0]             r_shift;
    logic [2:0]             r_pos;

    logic                   r_out_valid;
    lsle_pkg::t_out_word    r_out;

    logic [23:0]            w_order;
    logic [9:0]             w_pre_n;
    logic                   w_accept;
    logic                   w_can_emit;
    logic                   w_step;
    logic                   w_bit;
    logic                   w_last;
    logic [SYMBOL_BITS-1:0] w_zero_ext;
    logic [SYMBOL_BITS-1:0] w_one_ext;

    assign w_zero_ext = SYMBOL_BITS'(r_zero_sym);
    assign w_one_ext  = SYMBOL_BITS'(r_one_sym);

    // low color byte goes out first, each byte MSB first
    assign w_order = {i_in_word.color[7:0], i_in_word.color[15:8], i_in_word.color[23:16]};
    assign w_pre_n = (r_pre_len < 10'(PRE_LIMIT)) ? r_pre_len : 10'(PRE_LIMIT);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_can_emit  = !r_out_valid || !i_out_stall;
    assign w_step      = (r_state != ST_IDLE) && ((r_pos != 3'd7) || w_can_emit);
    assign w_bit       = (r_state == ST_DATA) ? r_sym[SYMBOL_BITS-1] : 1'b1;

    // last byte: pad byte, or a byte that closes exactly on the final data bit
    always_comb begin
        w_last = 1'b0;
        if (r_state == ST_PAD) begin
            w_last = 1'b1;
        end else if (r_state == ST_DATA && r_end && r_sym_cnt == SYM_LAST &&
                     r_data_cnt == DATA_LAST) begin
            w_last = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pre_len   <= lsle_pkg::PREAMBLE_RESET;
            r_zero_sym  <= lsle_pkg::ZERO_SYM_RESET;
            r_one_sym   <= lsle_pkg::ONE_SYM_RESET;
            r_pos       <= 3'd0;
            r_out_valid <= 1'b0;
            r_sym_cnt   <= '0;
            r_data_cnt  <= '0;
            r_pre_cnt   <= '0;
            r_end       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lsle_pkg::CFG_PREAMBLE_BITS: r_pre_len  <= i_cfg_data;
                    lsle_pkg::CFG_ZERO_SYMBOL:   r_zero_sym <= i_cfg_data[4:0];
                    lsle_pkg::CFG_ONE_SYMBOL:    r_one_sym  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_accept) begin
                r_color    <= w_order;
                r_sym      <= w_order[23] ? w_one_ext : w_zero_ext;
                r_sym_cnt  <= '0;
                r_data_cnt <= '0;
                r_end      <= i_in_word.end_frame;
                r_pre_cnt  <= w_pre_n;
                if (i_in_word.start_frame) begin
                    r_pos   <= 3'd0;
                    r_state <= (w_pre_n != 10'd0) ? ST_PRE : ST_DATA;
                end else begin
                    r_state <= ST_DATA;
                end
            end

            if (w_step) begin
                r_shift <= {r_shift[6:0], w_bit};
                r_pos   <= r_pos + 3'd1;
                if (r_pos == 3'd7) begin
                    r_out_valid     <= 1'b1;
                    r_out.line_byte <= {r_shift[6:0], w_bit};
                    r_out.last      <= w_last;
                end

                unique case (r_state)
                    ST_PRE: begin
                        r_pre_cnt <= r_pre_cnt - 10'd1;
                        if (r_pre_cnt == 10'd1) begin
                            r_state <= ST_DATA;
                        end
                    end
                    ST_DATA: begin
                        if (r_sym_cnt == SYM_LAST) begin
                            r_sym_cnt  <= '0;
                            r_color    <= {r_color[22:0], 1'b0};
                            r_sym      <= r_color[22] ? w_one_ext : w_zero_ext;
                            r_data_cnt <= r_data_cnt + 5'd1;
                            if (r_data_cnt == DATA_LAST) begin
                                r_state <= (r_end && r_pos != 3'd7) ? ST_PAD : ST_IDLE;
                            end
                        end else begin
                            r_sym_cnt <= r_sym_cnt + SCW'(1);
                            r_sym     <= {r_sym[SYMBOL_BITS-2:0], 1'b0};
                        end
                    end
                    ST_PAD: begin
                        if (r_pos == 3'd7) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(w_step && r_pos == 3'd7))
        else $error("completed byte would overwrite a held output word");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.start_frame) |=> (r_pos == 3'd0))
        else $error("frame start did not restart the bit position");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_pos == 3'd7 && w_last) |=> (r_state == ST_IDLE && r_pos == 3'd0))
        else $error("last byte emitted but the item is not finished");

    a_pad_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD) |-> (r_end && r_pos != 3'd0))
        else $error("padding without a frame end or on a byte boundary");

endmodule

@@ dv/led_symbol_line_encoder_test.sv @@
`timescale 1ns / 1ps

module led_symbol_line_encoder_test;

    localparam int SYM_BITS = 5;
    // clamp keeps one word at no more than MAX_BYTES output bytes
    localparam int unsigned PREAMBLE_CAP =
        lsle_pkg::MAX_BYTES * 8 - lsle_pkg::COLOR_BITS * SYM_BITS;
    localparam logic [lsle_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 24;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    lsle_pkg::t_in_word                i_in_word;
    logic                              o_out_valid;
    logic                              i_out_stall;
    lsle_pkg::t_out_word               o_out_word;
    logic                              i_cfg_we;
    logic [lsle_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [lsle_pkg::CFG_BITS-1:0]     i_cfg_data;

    led_symbol_line_encoder #(
        .SYMBOL_BITS(SYM_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // encoder copy of the configuration and packer state
    logic [9:0]  preamble_len;
    logic [4:0]  zero_sym;
    logic [4:0]  one_sym;
    logic [7:0]  pend_byte;
    int unsigned pend_pos;

    lsle_pkg::t_in_word    color_q[$];
    lsle_pkg::t_out_word   line_q[$];
    lsle_pkg::t_out_word   word_bytes[$];

    int          words_queued;
    int          words_taken;
    int          err_cnt;
    logic        in_accepted;
    logic        in_idle_on;
    logic        out_idle_on;
    int          in_gap;
    int          stall_left;

    function automatic int pick_len(input logic enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void shift_line_bit(input logic v);
        lsle_pkg::t_out_word w;
        if (!v) pend_byte[7 - pend_pos] = 1'b0;
        if (pend_pos == 7) begin
            w.line_byte = pend_byte;
            w.last = 1'b0;
            if (word_bytes.size() < lsle_pkg::MAX_BYTES) word_bytes.push_back(w);
            pend_byte = 8'hFF;
            pend_pos = 0;
        end else begin
            pend_pos++;
        end
    endfunction

    function automatic void encode_word(input lsle_pkg::t_in_word w);
        int unsigned         nbits;
        logic [7:0]          sym;
        lsle_pkg::t_out_word pad;
        word_bytes.delete();
        if (w.start_frame) begin
            nbits = (preamble_len < PREAMBLE_CAP) ? preamble_len : PREAMBLE_CAP;
            pend_byte = 8'hFF;
            pend_pos = 0;
            for (int i = 0; i < nbits; i++) shift_line_bit(1'b1);
        end
        // low color byte first, each byte MSB first
        for (int k = 0; k < 3; k++) begin
            for (int b = 7; b >= 0; b--) begin
                sym = w.color[8 * k + b] ? {3'b000, one_sym} : {3'b000, zero_sym};
                for (int s = SYM_BITS - 1; s >= 0; s--) shift_line_bit(sym[s]);
            end
        end
        if (w.end_frame) begin
            if (pend_pos != 0) begin
                pad.line_byte = pend_byte;
                pad.last = 1'b1;
                if (word_bytes.size() < lsle_pkg::MAX_BYTES) word_bytes.push_back(pad);
            end else if (word_bytes.size() > 0) begin
                word_bytes[word_bytes.size() - 1].last = 1'b1;
            end
            pend_byte = 8'hFF;
            pend_pos = 0;
        end
        foreach (word_bytes[i]) line_q.push_back(word_bytes[i]);
    endfunction

    always #6 i_clk = ~i_clk;

    // input driver
    always @(negedge i_clk) begin
        if (!i_in_valid || in_accepted) begin
            if (in_gap != 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (color_q.size() != 0) begin
                i_in_word <= color_q.pop_front();
                i_in_valid <= 1'b1;
                in_gap = pick_len(in_idle_on);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_len(out_idle_on);
        end
    end

    // monitor: predict on accepted input words, check accepted output words
    always @(posedge i_clk) begin
        lsle_pkg::t_out_word exp_w;
        in_accepted <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                encode_word(i_in_word);
                words_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (line_q.size() == 0) begin
                    $error("unexpected output word: line_byte %02h last %0b",
                           o_out_word.line_byte, o_out_word.last);
                    err_cnt++;
                end else begin
                    exp_w = line_q.pop_front();
                    if (o_out_word.line_byte !== exp_w.line_byte) begin
                        $error("line_byte: expected %02h, got %02h",
                               exp_w.line_byte, o_out_word.line_byte);
                        err_cnt++;
                    end
                    if (o_out_word.last !== exp_w.last) begin
                        $error("last: expected %0b, got %0b", exp_w.last, o_out_word.last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [lsle_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [9:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lsle_pkg::CFG_PREAMBLE_BITS: preamble_len = val;
            lsle_pkg::CFG_ZERO_SYMBOL:   zero_sym = val[4:0];
            lsle_pkg::CFG_ONE_SYMBOL:    one_sym = val[4:0];
            default: ;
        endcase
    endtask

    task automatic send(input logic [23:0] color, input logic sof, input logic eof);
        lsle_pkg::t_in_word w;
        w.color = color;
        w.start_frame = sof;
        w.end_frame = eof;
        color_q.push_back(w);
        words_queued++;
    endtask

    // wait for every word taken and every byte seen, then let the packer settle
    task automatic drain();
        @(negedge i_clk);
        while (words_taken != words_queued || line_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [23:0] rand_color();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'h000000;
        if (r == 1) return 24'hFFFFFF;
        return 24'($urandom());
    endfunction

    function automatic logic [9:0] rand_preamble();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 10'($urandom_range(0, 40));
        if (r < 8) return 10'($urandom_range(100, 200));
        return 10'($urandom_range(0, 1023));
    endfunction

    initial begin
        int cnt;
        int len;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = lsle_pkg::CFG_PREAMBLE_BITS;
        i_cfg_data = '0;
        in_accepted = 1'b0;
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        in_gap = 0;
        stall_left = 0;
        words_queued = 0;
        words_taken = 0;
        err_cnt = 0;
        preamble_len = lsle_pkg::PREAMBLE_RESET;
        zero_sym = lsle_pkg::ZERO_SYM_RESET;
        one_sym = lsle_pkg::ONE_SYM_RESET;
        pend_byte = 8'hFF;
        pend_pos = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults; preamble of 133 leaves 5 bits pending
        send(24'h000000, 1'b1, 1'b0);
        send(24'hFFFFFF, 1'b0, 1'b0);
        send(24'h123456, 1'b1, 1'b0);  // restart drops the pending bits
        send(24'hA5C3F0, 1'b0, 1'b1);  // end with padding
        send(24'h00FF00, 1'b0, 1'b1);  // end lands on a byte boundary
        send(24'h5A5A5A, 1'b1, 1'b1);
        drain();

        // over-long preamble gets clamped, extreme symbols, ignored index
        write_reg(lsle_pkg::CFG_PREAMBLE_BITS, 10'h3FF);
        write_reg(lsle_pkg::CFG_ZERO_SYMBOL, 10'h000);
        write_reg(lsle_pkg::CFG_ONE_SYMBOL, 10'h3FF);
        write_reg(CFG_UNUSED, 10'h3FF);
        send(24'hFFFFFF, 1'b1, 1'b0);
        send(24'h000000, 1'b0, 1'b1);
        send(24'h0F0F0F, 1'b1, 1'b1);
        drain();

        write_reg(lsle_pkg::CFG_PREAMBLE_BITS, 10'd0);
        write_reg(lsle_pkg::CFG_ZERO_SYMBOL, 10'h01F);
        write_reg(lsle_pkg::CFG_ONE_SYMBOL, 10'h3E0);
        send(24'h800001, 1'b1, 1'b0);
        send(24'hFEDCBA, 1'b0, 1'b1);
        send(24'h7F7F7F, 1'b1, 1'b1);
        drain();

        // one above the clamp
        write_reg(lsle_pkg::CFG_PREAMBLE_BITS, 10'(PREAMBLE_CAP + 1));
        write_reg(lsle_pkg::CFG_ZERO_SYMBOL, 10'b00000_10110);
        write_reg(lsle_pkg::CFG_ONE_SYMBOL, 10'b00000_01001);
        send(24'h3C3C3C, 1'b1, 1'b1);
        send(24'hC3C3C3, 1'b1, 1'b0);
        send(24'h96E1D2, 1'b0, 1'b0);
        send(24'h2B4D8F, 1'b0, 1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            in_idle_on = (ph != 1) && (ph != 3);
            out_idle_on = (ph != 2) && (ph != 3);
            write_reg(lsle_pkg::CFG_PREAMBLE_BITS, rand_preamble());
            write_reg(lsle_pkg::CFG_ZERO_SYMBOL, 10'($urandom_range(0, 1023)));
            write_reg(lsle_pkg::CFG_ONE_SYMBOL, 10'($urandom_range(0, 1023)));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 10'($urandom_range(0, 1023)));
            cnt = 0;
            while (cnt < 30) begin
                if ($urandom_range(0, 99) < 85) begin
                    len = $urandom_range(1, 6);
                    for (int j = 0; j < len; j++) send(rand_color(), j == 0, j == len - 1);
                    cnt += len;
                end else begin
                    send(rand_color(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    cnt++;
                end
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("led_symbol_line_encoder_test: done, clean");
        end else begin
            $display("led_symbol_line_encoder_test: done, errors");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("led_symbol_line_encoder_test: done, errors");
        $finish;
    end

endmodule
